// ----- sv/wbmp_type0_stream_validator_core_assert.svh -----
// Assertion macros shared by the WBMP validator RTL.
`ifndef WBMP_TYPE0_STREAM_VALIDATOR_CORE_ASSERT_SVH
`define WBMP_TYPE0_STREAM_VALIDATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define WBMP_ASSERT_SAME(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("wbmp validator assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define WBMP_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("wbmp validator assertion failed");

`endif

// ----- sv/wbmpsv_pkg.sv -----
// Types and constants of the WBMP type 0 stream validator.
package wbmpsv_pkg;

    typedef enum logic [2:0] {
        PH_TYPE   = 3'd0,
        PH_FIXED  = 3'd1,
        PH_WIDTH  = 3'd2,
        PH_HEIGHT = 3'd3,
        PH_DATA   = 3'd4
    } phase_t;

    typedef logic [2:0] status_t;

    localparam status_t ST_OK       = 3'd0;
    localparam status_t ST_TRUNC    = 3'd1;
    localparam status_t ST_TYPE     = 3'd2;
    localparam status_t ST_HEADER   = 3'd3;
    localparam status_t ST_DIMS     = 3'd4;
    localparam status_t ST_OVERFLOW = 3'd5;
    localparam status_t ST_DATASIZE = 3'd6;
    localparam status_t ST_PADDING  = 3'd7;

    // fixed header byte: bits 7 and 4..0 must be clear
    localparam logic [7:0]  FIXED_MASK    = 8'h9F;
    localparam logic [31:0] WIDTH_MAX     = 32'hFFFF_FFF8;
    localparam logic [2:0]  MB_OCTETS     = 3'd5;
    localparam logic [3:0]  HDR_COUNT_MAX = 4'd15;
    localparam logic [32:0] COUNT_MAX     = 33'h1_FFFF_FFFF;

    localparam int OUT_BITS  = 3 + 32 + 32 + 29 + 32 + 4;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

endpackage

// ----- sv/wbmp_type0_stream_validator_core.sv -----
// WBMP type 0 stream validator: header parse, geometry and pixel data checks.
// The result is registered: it is on m_axis in the cycle after the transfer of the last byte.
// Throughput: one byte per cycle; only a last byte waits, and only while a
//   previous result is still held in the output register.
// The 29x32 geometry multiply runs in the cycle the height field completes.
// Reset (rst_n low, asynchronous): parser expects a type byte, no result held.
`include "wbmp_type0_stream_validator_core_assert.svh"

module wbmp_type0_stream_validator_core
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] byte_value
    input  logic         s_axis_tlast,   // last_byte

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [2:0] status_code, [34:3] image_width, [66:35] image_height,
    // [95:67] bytes_per_row, [127:96] pixel_byte_total, [131:128] header_length,
    // [135:132] zero
    output logic [wbmpsv_pkg::OUT_BYTES*8-1:0] m_axis_tdata
);

    localparam int PadBits = wbmpsv_pkg::OUT_BYTES * 8 - wbmpsv_pkg::OUT_BITS;

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    wbmpsv_pkg::phase_t  phase_reg,     phase_next;
    logic [2:0]          octet_reg,     octet_next;
    logic [31:0]         acc_reg,       acc_next;
    logic [31:0]         width_reg,     width_next;
    logic [31:0]         height_reg,    height_next;
    logic [28:0]         rb_pre_reg,    rb_pre_next;   // (width+7)/8, ready early
    logic [28:0]         row_len_reg,   row_len_next;
    logic [31:0]         total_reg,     total_next;
    logic [3:0]          hdr_cnt_reg,   hdr_cnt_next;
    logic [32:0]         data_cnt_reg,  data_cnt_next;
    logic [28:0]         row_pos_reg,   row_pos_next;
    wbmpsv_pkg::status_t err_reg,       err_next;
    logic                pad_bad_reg,   pad_bad_next;

    // Result register
    logic                out_valid_reg;
    wbmpsv_pkg::status_t out_status_reg, out_status_next;
    logic [31:0]         out_width_reg;
    logic [31:0]         out_height_reg;
    logic [28:0]         out_rb_reg;
    logic [31:0]         out_total_reg;
    logic [3:0]          out_hlen_reg,   out_hlen_next;

    logic        s_xfer;
    logic        last_xfer;

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic [31:0] acc_shift;
    logic        acc_over;
    logic [2:0]  octet_inc;
    logic [32:0] rb_sum;
    logic [60:0] prod;
    logic        prod_over;
    logic [29:0] row_pos_inc;
    logic [7:0]  pad_mask;
    logic [32:0] span_sum;
    logic        header_done;

    assign acc_over    = |acc_reg[31:25];   // another 7 bits would not fit
    assign acc_shift   = {acc_reg[24:0], s_axis_tdata[6:0]};
    assign octet_inc   = octet_reg + 3'd1;
    assign rb_sum      = {1'b0, acc_shift} + 33'd7;
    assign prod        = 61'(rb_pre_reg) * 61'(acc_shift);
    assign prod_over   = |prod[60:32];
    assign row_pos_inc = {1'b0, row_pos_reg} + 30'd1;
    assign pad_mask    = 8'hFF >> width_reg[2:0];
    assign span_sum    = {1'b0, total_reg} + {29'd0, hdr_cnt_next};

    // A last byte may only pass when the result slot is free or draining.
    assign s_axis_tready = !out_valid_reg || m_axis_tready || !s_axis_tlast;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign last_xfer     = s_xfer && s_axis_tlast;

    // ------------------------------------------------------------------
    // Next-state logic, one byte per transfer
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next     = phase_reg;
        octet_next     = octet_reg;
        acc_next       = acc_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        rb_pre_next    = rb_pre_reg;
        row_len_next   = row_len_reg;
        total_next     = total_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        data_cnt_next  = data_cnt_reg;
        row_pos_next   = row_pos_reg;
        err_next       = err_reg;
        pad_bad_next   = pad_bad_reg;
        header_done    = 1'b0;

        if (s_xfer && err_reg == wbmpsv_pkg::ST_OK)
        begin
            unique case (phase_reg)
                wbmpsv_pkg::PH_TYPE:
                begin
                    hdr_cnt_next = 4'd1;
                    if (s_axis_tdata != 8'd0)
                        err_next = wbmpsv_pkg::ST_TYPE;
                    else
                        phase_next = wbmpsv_pkg::PH_FIXED;
                end
                wbmpsv_pkg::PH_FIXED:
                begin
                    hdr_cnt_next = hdr_cnt_reg + 4'd1;
                    if ((s_axis_tdata & wbmpsv_pkg::FIXED_MASK) != 8'd0)
                        err_next = wbmpsv_pkg::ST_HEADER;
                    else
                    begin
                        phase_next = wbmpsv_pkg::PH_WIDTH;
                        acc_next   = 32'd0;
                        octet_next = 3'd0;
                    end
                end
                wbmpsv_pkg::PH_WIDTH,
                wbmpsv_pkg::PH_HEIGHT:
                begin
                    if (hdr_cnt_reg < wbmpsv_pkg::HDR_COUNT_MAX)
                        hdr_cnt_next = hdr_cnt_reg + 4'd1;
                    if (acc_over)
                        err_next = wbmpsv_pkg::ST_OVERFLOW;
                    else if (s_axis_tdata[7])
                    begin
                        // continuation octet
                        acc_next   = acc_shift;
                        octet_next = octet_inc;
                        if (octet_inc >= wbmpsv_pkg::MB_OCTETS)
                            err_next = wbmpsv_pkg::ST_OVERFLOW;
                    end
                    else if (phase_reg == wbmpsv_pkg::PH_WIDTH)
                    begin
                        width_next  = acc_shift;
                        rb_pre_next = rb_sum[31:3];
                        phase_next  = wbmpsv_pkg::PH_HEIGHT;
                        acc_next    = 32'd0;
                        octet_next  = 3'd0;
                    end
                    else
                    begin
                        // height complete: geometry checks
                        acc_next    = acc_shift;
                        height_next = acc_shift;
                        if (width_reg == 32'd0 || acc_shift == 32'd0)
                            err_next = wbmpsv_pkg::ST_DIMS;
                        else if (width_reg > wbmpsv_pkg::WIDTH_MAX)
                            err_next = wbmpsv_pkg::ST_OVERFLOW;
                        else
                        begin
                            row_len_next = rb_pre_reg;
                            if (prod_over)
                                err_next = wbmpsv_pkg::ST_OVERFLOW;
                            else
                            begin
                                total_next    = prod[31:0];
                                phase_next    = wbmpsv_pkg::PH_DATA;
                                data_cnt_next = 33'd0;
                                row_pos_next  = 29'd0;
                                header_done   = 1'b1;
                            end
                        end
                    end
                end
                wbmpsv_pkg::PH_DATA:
                begin
                    if (data_cnt_reg < {1'b0, total_reg})
                    begin
                        if (row_pos_inc >= {1'b0, row_len_reg})
                        begin
                            // last byte of a row: unused low bits must be zero
                            if (width_reg[2:0] != 3'd0 && (s_axis_tdata & pad_mask) != 8'd0)
                                pad_bad_next = 1'b1;
                            row_pos_next = 29'd0;
                        end
                        else
                            row_pos_next = row_pos_inc[28:0];
                    end
                    if (data_cnt_reg < wbmpsv_pkg::COUNT_MAX)
                        data_cnt_next = data_cnt_reg + 33'd1;
                end
                default:
                begin
                    err_next = err_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result for a last byte, from the post-update state
    // ------------------------------------------------------------------
    always_comb
    begin
        out_hlen_next = 4'd0;
        priority if (err_next != wbmpsv_pkg::ST_OK)
            out_status_next = err_next;
        else if (phase_next != wbmpsv_pkg::PH_DATA)
            out_status_next = wbmpsv_pkg::ST_TRUNC;
        else if (header_done)
        begin
            // header ended on the last byte: no pixel bytes, total is nonzero
            out_hlen_next   = hdr_cnt_next;
            out_status_next = wbmpsv_pkg::ST_DATASIZE;
        end
        else
        begin
            out_hlen_next = hdr_cnt_next;
            if (data_cnt_next != {1'b0, total_reg} || span_sum[32])
                out_status_next = wbmpsv_pkg::ST_DATASIZE;
            else if (pad_bad_next)
                out_status_next = wbmpsv_pkg::ST_PADDING;
            else
                out_status_next = wbmpsv_pkg::ST_OK;
        end
    end

    // ------------------------------------------------------------------
    // State registers; a last-byte transfer returns to the reset state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= wbmpsv_pkg::PH_TYPE;
            octet_reg     <= 3'd0;
            acc_reg       <= 32'd0;
            width_reg     <= 32'd0;
            height_reg    <= 32'd0;
            rb_pre_reg    <= 29'd0;
            row_len_reg   <= 29'd0;
            total_reg     <= 32'd0;
            hdr_cnt_reg   <= 4'd0;
            data_cnt_reg  <= 33'd0;
            row_pos_reg   <= 29'd0;
            err_reg       <= wbmpsv_pkg::ST_OK;
            pad_bad_reg   <= 1'b0;
        end
        else if (last_xfer)
        begin
            phase_reg     <= wbmpsv_pkg::PH_TYPE;
            octet_reg     <= 3'd0;
            acc_reg       <= 32'd0;
            width_reg     <= 32'd0;
            height_reg    <= 32'd0;
            rb_pre_reg    <= 29'd0;
            row_len_reg   <= 29'd0;
            total_reg     <= 32'd0;
            hdr_cnt_reg   <= 4'd0;
            data_cnt_reg  <= 33'd0;
            row_pos_reg   <= 29'd0;
            err_reg       <= wbmpsv_pkg::ST_OK;
            pad_bad_reg   <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            octet_reg     <= octet_next;
            acc_reg       <= acc_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            rb_pre_reg    <= rb_pre_next;
            row_len_reg   <= row_len_next;
            total_reg     <= total_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            data_cnt_reg  <= data_cnt_next;
            row_pos_reg   <= row_pos_next;
            err_reg       <= err_next;
            pad_bad_reg   <= pad_bad_next;
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (last_xfer)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // Result payload, loaded on a last-byte transfer
    always_ff @(posedge clk)
    begin
        if (last_xfer)
        begin
            out_status_reg <= out_status_next;
            out_width_reg  <= width_next;
            out_height_reg <= height_next;
            out_rb_reg     <= row_len_next;
            out_total_reg  <= total_next;
            out_hlen_reg   <= out_hlen_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PadBits{1'b0}}, out_hlen_reg, out_total_reg, out_rb_reg,
                            out_height_reg, out_width_reg, out_status_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `WBMP_ASSERT_NEXT(a_last_restarts, last_xfer, phase_reg == wbmpsv_pkg::PH_TYPE && err_reg == wbmpsv_pkg::ST_OK && data_cnt_reg == 33'd0)
    `WBMP_ASSERT_SAME(a_result_from_last, $rose(out_valid_reg), $past(last_xfer))
    `WBMP_ASSERT_SAME(a_data_geometry, phase_reg == wbmpsv_pkg::PH_DATA, total_reg != 32'd0 && row_len_reg != 29'd0)
    `WBMP_ASSERT_SAME(a_row_pos_bound, phase_reg == wbmpsv_pkg::PH_DATA, row_pos_reg < row_len_reg)

endmodule

// ----- dv/wbmp_stream_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the WBMP type 0 validator: parser model plus result comparison.
module wbmp_stream_checker
    import wbmpsv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [7:0]             s_tdata,
    input  logic                   s_tlast,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_BYTES*8-1:0] m_tdata,
    output int unsigned            fail_count,
    output int unsigned            pending
);

    typedef struct packed {
        status_t     status;
        logic [31:0] width;
        logic [31:0] height;
        logic [28:0] row_len;
        logic [31:0] pix_total;
        logic [3:0]  hdr_len;
    } verdict_t;

    verdict_t    verdicts_q[$];
    int unsigned errors;

    // parser image
    phase_t      phase;
    logic [2:0]  octets;
    logic [31:0] accum;
    logic [31:0] width_q;
    logic [31:0] height_q;
    logic [28:0] row_len_q;
    logic [31:0] pix_total_q;
    logic [3:0]  hdr_cnt;
    logic [32:0] data_cnt;
    logic [28:0] row_pos;
    status_t     err;
    logic        pad_bad;

    assign fail_count = errors;

    task automatic clear_parser();
        phase       = PH_TYPE;
        octets      = '0;
        accum       = '0;
        width_q     = '0;
        height_q    = '0;
        row_len_q   = '0;
        pix_total_q = '0;
        hdr_cnt     = '0;
        data_cnt    = '0;
        row_pos     = '0;
        err         = ST_OK;
        pad_bad     = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got, inout bit bad);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            bad = 1'b1;
        end
    endtask

    initial
    begin
        errors  = 0;
        pending = 0;
        clear_parser();
    end

    always @(posedge clk or negedge rst_n)
    begin : model
        logic [63:0] rb;
        logic [63:0] prod;
        logic [32:0] room;
        logic [7:0]  pad_mask;
        logic        ovf;
        logic        done;
        verdict_t    want;
        verdict_t    got;
        bit          bad;

        if (!rst_n)
        begin
            clear_parser();
            verdicts_q.delete();
            pending = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (err == ST_OK)
                begin
                    case (phase)
                        PH_TYPE:
                        begin
                            hdr_cnt = 4'd1;
                            if (s_tdata != 8'h00)
                                err = ST_TYPE;
                            else
                                phase = PH_FIXED;
                        end
                        PH_FIXED:
                        begin
                            hdr_cnt = hdr_cnt + 4'd1;
                            if ((s_tdata & FIXED_MASK) != 8'h00)
                                err = ST_HEADER;
                            else
                            begin
                                phase  = PH_WIDTH;
                                accum  = '0;
                                octets = '0;
                            end
                        end
                        PH_WIDTH, PH_HEIGHT:
                        begin
                            if (hdr_cnt < HDR_COUNT_MAX)
                                hdr_cnt = hdr_cnt + 4'd1;
                            ovf  = 1'b0;
                            done = 1'b0;
                            // a further octet would shift bits out of 32
                            if (accum > 32'h01FF_FFFF)
                                ovf = 1'b1;
                            else
                            begin
                                accum = {accum[24:0], s_tdata[6:0]};
                                if (!s_tdata[7])
                                    done = 1'b1;
                                else
                                begin
                                    octets = octets + 3'd1;
                                    if (octets >= MB_OCTETS)
                                        ovf = 1'b1;
                                end
                            end
                            if (ovf)
                                err = ST_OVERFLOW;
                            else if (done && phase == PH_WIDTH)
                            begin
                                width_q = accum;
                                phase   = PH_HEIGHT;
                                accum   = '0;
                                octets  = '0;
                            end
                            else if (done)
                            begin
                                height_q = accum;
                                if (width_q == 32'd0 || height_q == 32'd0)
                                    err = ST_DIMS;
                                else if (width_q > WIDTH_MAX)
                                    err = ST_OVERFLOW;
                                else
                                begin
                                    rb          = ({32'd0, width_q} + 64'd7) >> 3;
                                    row_len_q   = rb[28:0];
                                    prod        = rb * {32'd0, height_q};
                                    if (prod > 64'h0000_0000_FFFF_FFFF)
                                        err = ST_OVERFLOW;
                                    else
                                    begin
                                        pix_total_q = prod[31:0];
                                        phase       = PH_DATA;
                                        data_cnt    = '0;
                                        row_pos     = '0;
                                    end
                                end
                            end
                        end
                        PH_DATA:
                        begin
                            // surplus bytes are only counted
                            if (data_cnt < {1'b0, pix_total_q})
                            begin
                                if ({3'd0, row_pos} + 32'd1 >= {3'd0, row_len_q})
                                begin
                                    pad_mask = 8'hFF >> width_q[2:0];
                                    if (width_q[2:0] != 3'd0 && (s_tdata & pad_mask) != 8'h00)
                                        pad_bad = 1'b1;
                                    row_pos = '0;
                                end
                                else
                                    row_pos = row_pos + 29'd1;
                            end
                            if (data_cnt < COUNT_MAX)
                                data_cnt = data_cnt + 33'd1;
                        end
                        default:
                        begin
                        end
                    endcase
                end

                if (s_tlast)
                begin
                    want.width     = width_q;
                    want.height    = height_q;
                    want.row_len   = row_len_q;
                    want.pix_total = pix_total_q;
                    want.hdr_len   = 4'd0;
                    if (err != ST_OK)
                        want.status = err;
                    else if (phase != PH_DATA)
                        want.status = ST_TRUNC;
                    else
                    begin
                        want.hdr_len = hdr_cnt;
                        room = {29'd0, hdr_cnt} + {1'b0, pix_total_q};
                        if (data_cnt != {1'b0, pix_total_q} || room[32])
                            want.status = ST_DATASIZE;
                        else if (pad_bad)
                            want.status = ST_PADDING;
                        else
                            want.status = ST_OK;
                    end
                    verdicts_q.push_back(want);
                    clear_parser();
                end
            end

            if (m_tvalid && m_tready)
            begin
                got.status    = m_tdata[2:0];
                got.width     = m_tdata[34:3];
                got.height    = m_tdata[66:35];
                got.row_len   = m_tdata[95:67];
                got.pix_total = m_tdata[127:96];
                got.hdr_len   = m_tdata[131:128];
                if (verdicts_q.size() == 0)
                begin
                    $display("%0t: result with none expected, expected none actual %0h",
                             $time, got);
                    errors = errors + 1;
                end
                else
                begin
                    want = verdicts_q.pop_front();
                    bad  = 1'b0;
                    check_field("status_code", {29'd0, want.status}, {29'd0, got.status}, bad);
                    check_field("image_width", want.width, got.width, bad);
                    check_field("image_height", want.height, got.height, bad);
                    check_field("bytes_per_row", {3'd0, want.row_len},
                                {3'd0, got.row_len}, bad);
                    check_field("pixel_byte_total", want.pix_total, got.pix_total, bad);
                    check_field("header_length", {28'd0, want.hdr_len},
                                {28'd0, got.hdr_len}, bad);
                    if (bad)
                        errors = errors + 1;
                end
            end
            pending = verdicts_q.size();
        end
    end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Top of the WBMP type 0 validator bench: clock, reset, file stimulus and verdict.
module testbench;
    import wbmpsv_pkg::*;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic [7:0]             s_axis_tdata  = 8'h00;   // [7:0] byte_value
    logic                   s_axis_tlast  = 1'b0;    // last_byte
    logic                   m_axis_tready = 1'b0;
    logic                   s_axis_tready;
    logic                   m_axis_tvalid;
    // [2:0] status, [34:3] width, [66:35] height, [95:67] row bytes,
    // [127:96] pixel bytes, [131:128] header length
    logic [OUT_BYTES*8-1:0] m_axis_tdata;

    int unsigned fail_count;
    int unsigned pending;

    // bytes of the file being built; the final one goes out with tlast
    logic [7:0]  file_q[$];
    int unsigned bytes_sent = 0;
    bit          calm       = 1'b0;

    always #5 clk = ~clk;

    wbmp_type0_stream_validator_core u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    wbmp_stream_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_axis_tvalid),
        .s_tready   (s_axis_tready),
        .s_tdata    (s_axis_tdata),
        .s_tlast    (s_axis_tlast),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_tdata    (m_axis_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Idle length before a byte: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Multibyte integer: 7 bits per octet, MSB set on all but the last,
    // optionally preceded by empty continuation octets.
    task automatic put_mb(input logic [31:0] v, input int lead);
        int          n;
        logic [31:0] part;
        n = 1;
        while (n < 5 && (v >> (7 * n)) != 0)
            n++;
        repeat (lead)
            file_q.push_back(8'h80);
        for (int i = n - 1; i >= 0; i--)
        begin
            part = v >> (7 * i);
            file_q.push_back({(i > 0), part[6:0]});
        end
    endtask

    // Complete image: header, then row data with size off by adj bytes;
    // with clean set the padding bits of each row end are cleared.
    task automatic put_image(input int w, input int h, input int lw, input int lh,
                             input int adj, input bit clean);
        int         rb;
        int         total;
        logic [1:0] fx;
        logic [7:0] b;
        rb    = (w + 7) / 8;
        total = rb * h + adj;
        if (total < 0)
            total = 0;
        fx = 2'($urandom);
        file_q.push_back(8'h00);
        // bits 6:5 of the fixed header are free
        file_q.push_back({1'b0, fx, 5'b0});
        put_mb(w, lw);
        put_mb(h, lh);
        for (int j = 0; j < total; j++)
        begin
            b = 8'($urandom);
            if (clean && (w % 8) != 0 && (j % rb) == rb - 1)
                b = b & ~(8'hFF >> (w % 8));
            file_q.push_back(b);
        end
    endtask

    // One transfer on the slave side; entered and left at a falling edge.
    task automatic push_byte(input logic [7:0] b, input logic lst);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic send_file();
        calm = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < file_q.size(); i++)
        begin
            push_byte(file_q[i], i == file_q.size() - 1);
            bytes_sent++;
        end
        file_q.delete();
    endtask

    // Result sink: ready bursts broken by stalls, mostly short.
    initial
    begin : sink
        int r;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge clk);
            r = $urandom_range(0, 99);
            if (r >= 40)
            begin
                m_axis_tready <= 1'b0;
                repeat ((r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 60))
                    @(negedge clk);
            end
        end
    end

    initial
    begin : stim
        int kind;
        int w;
        int h;
        int cut;
        int adj;
        int len;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed files
        file_q = '{8'h01};                                   // bad type byte
        send_file();
        file_q = '{8'h00};                                   // ends after type byte
        send_file();
        file_q = '{8'h00, 8'h80};                            // reserved header bit set
        send_file();
        file_q = '{8'h00, 8'h60, 8'h01, 8'h01};              // header only, no pixels
        send_file();
        file_q = '{8'h00, 8'h00, 8'h01, 8'h01, 8'h00};       // 1x1, clean
        send_file();
        file_q = '{8'h00, 8'h00, 8'h01, 8'h01, 8'h01};       // 1x1, dirty padding
        send_file();
        file_q = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h00};       // zero width
        send_file();
        // width 0xFFFFFFFF: past the widest allowed
        file_q = '{8'h00, 8'h00, 8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h01, 8'h00};
        send_file();
        // accumulator too big for a fifth octet
        file_q = '{8'h00, 8'h00, 8'h90, 8'h80, 8'h80, 8'h80, 8'h00};
        send_file();
        // fifth octet still continues
        file_q = '{8'h00, 8'h00, 8'h81, 8'h80, 8'h80, 8'h80, 8'h80, 8'h01};
        send_file();
        // widest row, data far too short
        file_q = '{8'h00, 8'h00, 8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h78, 8'h01, 8'hAA};
        send_file();
        // widest row times nine exceeds 32 bits
        file_q = '{8'h00, 8'h00, 8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h78, 8'h09, 8'h00};
        send_file();
        put_image(8, 2, 0, 0, 0, 1'b1);                      // no padding bits
        send_file();
        put_image(9, 1, 3, 4, 0, 1'b1);                      // zero-prefixed fields
        send_file();
        put_image(3, 2, 0, 0, 2, 1'b1);                      // surplus pixel bytes
        send_file();

        // random files
        while (bytes_sent < 1900)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 80)
            begin
                w = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 160)
                                                : $urandom_range(1, 40);
                h = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                                : $urandom_range(1, 6);
                if (w > 60 && h > 6)
                    h = $urandom_range(1, 4);
                len = $urandom_range(0, 99);
                adj = (len < 80) ? 0 : (len < 90) ? -1 : $urandom_range(1, 3);
                put_image(w, h,
                          ($urandom_range(0, 99) < 85) ? 0 : $urandom_range(0, 4),
                          ($urandom_range(0, 99) < 85) ? 0 : $urandom_range(0, 4),
                          adj, $urandom_range(0, 3) != 0);
                // part of them cut short anywhere
                if (kind >= 65)
                begin
                    cut = $urandom_range(1, file_q.size());
                    while (file_q.size() > cut)
                        void'(file_q.pop_back());
                end
            end
            else if (kind < 90)
            begin
                // raw noise, often with a plausible start
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                    file_q.push_back(8'($urandom));
                if ($urandom_range(0, 1) == 1)
                    file_q[0] = 8'h00;
            end
            else
            begin
                // full-range geometry, few data bytes
                file_q.push_back(8'h00);
                file_q.push_back(8'h00);
                put_mb($urandom, 0);
                put_mb(($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 16), 0);
                len = $urandom_range(0, 2);
                for (int i = 0; i < len; i++)
                    file_q.push_back(8'($urandom));
            end
            send_file();
        end

        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        // drain: a result is registered in the cycle after its last byte
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
